>>> src/z_ordered_rectangle_stack_unit_assert.svh
`ifndef Z_ORDERED_RECTANGLE_STACK_UNIT_ASSERT_SVH
`define Z_ORDERED_RECTANGLE_STACK_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define ZORS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define ZORS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/zors_pkg.sv
package zors_pkg;

    // stack depth and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // port field widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;
    localparam int HIT_W      = 6;
    localparam int NUM_W      = 7;

    // item kinds
    localparam logic [2:0] KIND_ADD        = 3'd0;
    localparam logic [2:0] KIND_FIND       = 3'd1;
    localparam logic [2:0] KIND_RAISE      = 3'd2;
    localparam logic [2:0] KIND_LOWER      = 3'd3;
    localparam logic [2:0] KIND_REMOVE     = 3'd4;
    localparam logic [2:0] KIND_REMOVE_ALL = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // one stored rectangle
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic        [14:0] w;
        logic        [14:0] h;
    } rect_t;

    // point under test
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } point_t;

endpackage

>>> src/zors_cover.sv
module zors_cover
(
    input  zors_pkg::rect_t  rect,
    input  zors_pkg::point_t pt,
    output logic             hit
);

    logic signed [16:0] x1;
    logic signed [16:0] x2;
    logic signed [16:0] y1;
    logic signed [16:0] y2;
    logic signed [16:0] px;
    logic signed [16:0] py;

    // edges widened by one bit so the far edge cannot overflow
    assign x1 = {rect.left[15], rect.left};
    assign y1 = {rect.top[15], rect.top};
    assign x2 = $signed(x1 + {2'b00, rect.w});
    assign y2 = $signed(y1 + {2'b00, rect.h});
    assign px = {pt.x[15], pt.x};
    assign py = {pt.y[15], pt.y};

    // both edges inclusive
    assign hit = (px >= x1) && (px <= x2) && (py >= y1) && (py <= y2);

endmodule

>>> src/z_ordered_rectangle_stack_unit.sv
// channel | direction | tvalid/tready | payload
// s_      | in        | one word/item | tuser: kind; tdata: pos_x, pos_y, width, height
// m_      | out       | one word/item | tuser: status; tdata: hit, removed, entry count
//
// from one taken word to the next: add writes at once and goes straight to the result; find
// scans every entry; raise and lower add a shift pass and a place step, remove a shift
// pass; remove all compacts during its single scan.
// every pass goes through the one read port of the rectangle memory, one entry a cycle.
// reset clears the entry count; memory contents need no clearing.
// a new word is taken while an earlier result still waits on m_; a stalled result
// holds the block at its final step until taken.
module z_ordered_rectangle_stack_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] pos_x, [31:16] pos_y, [46:32] rect_width, [61:47] rect_height
    input  logic [zors_pkg::IN_DATA_W-1:0]     s_tdata,
    // [2:0] kind
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [5:0] hit_index, [12:6] removed_count, [19:13] entry_count
    output logic [zors_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [1:0]                         m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [2:0]                      kind_reg;
    zors_pkg::point_t                pt_reg;
    logic [zors_pkg::CNT_W-1:0]      count_reg;
    logic [zors_pkg::CNT_W-1:0]      rd_idx_reg;
    logic                            pipe_vld_reg;
    logic [zors_pkg::IDX_W-1:0]      pipe_idx_reg;
    logic [zors_pkg::CNT_W-1:0]      wr_k_reg;
    logic                            found_reg;
    logic [zors_pkg::IDX_W-1:0]      hit_reg;
    zors_pkg::rect_t                 saved_reg;
    logic [zors_pkg::CNT_W-1:0]      removed_reg;
    logic [1:0]                      status_reg;
    logic [zors_pkg::CNT_W-1:0]      left_reg;
    logic [zors_pkg::IDX_W-1:0]      src_reg;
    logic                            m_tvalid_reg;
    logic [zors_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    // rectangle memory
    zors_pkg::rect_t                 mem [zors_pkg::CAPACITY];
    zors_pkg::rect_t                 rd_data_reg;
    logic                            mem_we;
    logic [zors_pkg::IDX_W-1:0]      mem_waddr;
    zors_pkg::rect_t                 mem_wdata;
    logic                            mem_re;
    logic [zors_pkg::IDX_W-1:0]      mem_raddr;

    logic                            cover_hit;
    logic                            is_lower;
    logic                            is_rm_all;
    logic                            has_room;
    zors_pkg::rect_t                 in_rect;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign is_lower  = (kind_reg == zors_pkg::KIND_LOWER);
    assign is_rm_all = (kind_reg == zors_pkg::KIND_REMOVE_ALL);
    assign has_room  = (count_reg < zors_pkg::CNT_W'(zors_pkg::CAPACITY));

    assign in_rect.left = s_tdata[15:0];
    assign in_rect.top  = s_tdata[31:16];
    assign in_rect.w    = s_tdata[46:32];
    assign in_rect.h    = s_tdata[61:47];

    // hit test on the word just read
    zors_cover u_cover
    (
        .rect (rd_data_reg),
        .pt   (pt_reg),
        .hit  (cover_hit)
    );

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = saved_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == zors_pkg::KIND_ADD) && has_room)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = count_reg[zors_pkg::IDX_W-1:0];
                    mem_wdata = in_rect;
                end
            end
            ST_SCAN:
            begin
                mem_re    = (rd_idx_reg < count_reg);
                mem_raddr = rd_idx_reg[zors_pkg::IDX_W-1:0];
                // compaction keeps uncovered entries, moving them down
                if (is_rm_all && pipe_vld_reg && !cover_hit &&
                    (wr_k_reg[zors_pkg::IDX_W-1:0] != pipe_idx_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_k_reg[zors_pkg::IDX_W-1:0];
                    mem_wdata = rd_data_reg;
                end
            end
            ST_SHIFT:
            begin
                mem_re    = (left_reg != '0);
                mem_raddr = src_reg;
                if (pipe_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pipe_idx_reg;
                    mem_wdata = rd_data_reg;
                end
            end
            ST_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = is_lower ? '0
                          : zors_pkg::IDX_W'(count_reg - zors_pkg::CNT_W'(1));
            end
            ST_FINISH:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= '0;
            pt_reg       <= '0;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            pipe_vld_reg <= 1'b0;
            pipe_idx_reg <= '0;
            wr_k_reg     <= '0;
            found_reg    <= 1'b0;
            hit_reg      <= '0;
            saved_reg    <= '0;
            removed_reg  <= '0;
            status_reg   <= zors_pkg::STATUS_OK;
            left_reg     <= '0;
            src_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= zors_pkg::STATUS_OK;
        end
        else
        begin
            // a taken result word frees the output register
            if (m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg     <= s_tuser;
                        pt_reg.x     <= s_tdata[15:0];
                        pt_reg.y     <= s_tdata[31:16];
                        rd_idx_reg   <= '0;
                        pipe_vld_reg <= 1'b0;
                        wr_k_reg     <= '0;
                        found_reg    <= 1'b0;
                        removed_reg  <= '0;
                        if (s_tuser == zors_pkg::KIND_ADD)
                        begin
                            if (has_room)
                            begin
                                hit_reg    <= count_reg[zors_pkg::IDX_W-1:0];
                                status_reg <= zors_pkg::STATUS_OK;
                                count_reg  <= count_reg + zors_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                hit_reg    <= '0;
                                status_reg <= zors_pkg::STATUS_FULL;
                            end
                            state_reg <= ST_FINISH;
                        end
                        else if (s_tuser <= zors_pkg::KIND_REMOVE_ALL)
                        begin
                            hit_reg    <= '0;
                            status_reg <= zors_pkg::STATUS_OK;
                            state_reg  <= ST_SCAN;
                        end
                        else
                        begin
                            hit_reg    <= '0;
                            status_reg <= zors_pkg::STATUS_OK;
                            state_reg  <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN:
                begin
                    pipe_vld_reg <= mem_re;
                    pipe_idx_reg <= rd_idx_reg[zors_pkg::IDX_W-1:0];
                    if (mem_re)
                    begin
                        rd_idx_reg <= rd_idx_reg + zors_pkg::CNT_W'(1);
                    end
                    // compare the word read last cycle
                    if (pipe_vld_reg)
                    begin
                        if (cover_hit)
                        begin
                            found_reg <= 1'b1;
                            hit_reg   <= pipe_idx_reg;
                            saved_reg <= rd_data_reg;
                            if (is_rm_all)
                            begin
                                removed_reg <= removed_reg + zors_pkg::CNT_W'(1);
                            end
                        end
                        else if (is_rm_all)
                        begin
                            wr_k_reg <= wr_k_reg + zors_pkg::CNT_W'(1);
                        end
                    end
                    // pass done: pick the follow-up step
                    if (!mem_re && !pipe_vld_reg)
                    begin
                        if (!found_reg)
                        begin
                            status_reg <= zors_pkg::STATUS_MISS;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            priority case (kind_reg)
                                zors_pkg::KIND_REMOVE_ALL:
                                begin
                                    count_reg <= wr_k_reg;
                                    state_reg <= ST_FINISH;
                                end
                                zors_pkg::KIND_RAISE, zors_pkg::KIND_REMOVE:
                                begin
                                    left_reg  <= count_reg - zors_pkg::CNT_W'(1)
                                               - zors_pkg::CNT_W'(hit_reg);
                                    src_reg   <= hit_reg + zors_pkg::IDX_W'(1);
                                    state_reg <= ST_SHIFT;
                                end
                                zors_pkg::KIND_LOWER:
                                begin
                                    left_reg  <= zors_pkg::CNT_W'(hit_reg);
                                    src_reg   <= hit_reg - zors_pkg::IDX_W'(1);
                                    state_reg <= ST_SHIFT;
                                end
                                default:
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            endcase
                        end
                    end
                end
                ST_SHIFT:
                begin
                    pipe_vld_reg <= mem_re;
                    pipe_idx_reg <= is_lower ? src_reg + zors_pkg::IDX_W'(1)
                                             : src_reg - zors_pkg::IDX_W'(1);
                    if (mem_re)
                    begin
                        left_reg <= left_reg - zors_pkg::CNT_W'(1);
                        src_reg  <= is_lower ? src_reg - zors_pkg::IDX_W'(1)
                                             : src_reg + zors_pkg::IDX_W'(1);
                    end
                    if (!mem_re && !pipe_vld_reg)
                    begin
                        if (kind_reg == zors_pkg::KIND_REMOVE)
                        begin
                            count_reg   <= count_reg - zors_pkg::CNT_W'(1);
                            removed_reg <= zors_pkg::CNT_W'(1);
                            state_reg   <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_PLACE;
                        end
                    end
                end
                ST_PLACE:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // hand over the result word once the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= zors_pkg::OUT_DATA_W'({
                            zors_pkg::NUM_W'(count_reg),
                            zors_pkg::NUM_W'(removed_reg),
                            zors_pkg::HIT_W'(hit_reg)});
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/zors_checker.sv
`include "z_ordered_rectangle_stack_unit_assert.svh"

module zors_sva
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [zors_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);

    // a stalled result word holds
    `ZORS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // the block is busy in the cycle after each taken word
    `ZORS_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

    // a miss or a full stack reports no hit and no removal
    `ZORS_ASSERT_IMP(a_fail_clean, m_tvalid && (m_tuser == zors_pkg::STATUS_MISS || m_tuser == zors_pkg::STATUS_FULL), m_tdata[12:0] == 13'd0, "failed item reports hit or removal")

    // full status only with the stack at capacity
    `ZORS_ASSERT_IMP(a_full_count, m_tvalid && m_tuser == zors_pkg::STATUS_FULL, m_tdata[19:13] == zors_pkg::NUM_W'(zors_pkg::CAPACITY), "full status below capacity")

    // removal only with an ok status
    `ZORS_ASSERT_IMP(a_removed_ok, m_tvalid && m_tdata[12:6] != 7'd0, m_tuser == zors_pkg::STATUS_OK, "removal reported with failed status")

endmodule

bind z_ordered_rectangle_stack_unit zors_sva u_zors_sva (.*);
